FILE: src/qftm_pkg.sv
package qftm_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_FLUSH   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    enq;        // write value at tail
    logic    start;      // begin scan at head
    logic    step;       // advance scan by one entry
    logic    hit;        // drop entries through scan pointer
    logic    load;       // capture result
    status_t res_status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
  } dp_stat_t;

endpackage

FILE: src/queue_flush_through_match_top.sv
// Enqueue, overflow and empty-flush transactions: result registered on accept.
// Flush with entries: one stored entry compared per cycle through the single memory
// read port, from the head until a match or the last stored entry.
// Enqueue and empty flush do not hold the sequencer; a scanning flush blocks input
// until its scan ends.
// Reset (rst, synchronous, active high) empties the queue; stored data is not cleared.
module queue_flush_through_match_top #(
  parameter int DEPTH = qftm_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [3:0]         count
);

  // Storage is a circular buffer: a flush that hits only moves the head
  // past the matching entry, which keeps later entries in order without
  // any compaction pass.
  // Next transaction is taken once the result register is free or being drained.
  qftm_pkg::dp_cmd_t  cmd;
  qftm_pkg::dp_stat_t stat;

  // Sequencer: accept, scan, result handshake.
  qftm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Memory, pointers, fill level, comparator and result registers.
  qftm_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .status (status),
    .count  (count)
  );

endmodule

FILE: src/qftm_ctrl.sv
module qftm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  output logic               out_valid,
  input  logic               out_ready,
  input  qftm_pkg::dp_stat_t stat,
  output qftm_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = qftm_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == qftm_pkg::ACT_ENQUEUE) begin
            cmd.enq        = !stat.full;
            cmd.load       = 1'b1;
            cmd.res_status = stat.full ? qftm_pkg::ST_OVERFLOW : qftm_pkg::ST_OK;
          end else if (stat.empty) begin
            cmd.load       = 1'b1;
            cmd.res_status = qftm_pkg::ST_EMPTY;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.hit        = 1'b1;
          cmd.load       = 1'b1;
          cmd.res_status = qftm_pkg::ST_OK;
          state_next     = S_IDLE;
        end else if (stat.last) begin
          cmd.load       = 1'b1;
          cmd.res_status = qftm_pkg::ST_NOTFOUND;
          state_next     = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: src/qftm_dpath.sv
module qftm_dpath #(
  parameter int DEPTH = qftm_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  value,
  input  qftm_pkg::dp_cmd_t   cmd,
  output qftm_pkg::dp_stat_t  stat,
  output logic [1:0]          status,
  output logic [3:0]          count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic signed [31:0] key;
  logic [AW-1:0]      head, tail, rd_ptr, rd_addr;
  logic [AW-1:0]      idx;
  logic [CW-1:0]      fill, fill_next;
  logic [CW-1:0]      scanned;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign scanned    = CW'(idx) + CW'(1);
  assign stat.full  = (fill == CW'(DEPTH));
  assign stat.empty = (fill == '0);
  assign stat.match = (rdata == key);
  assign stat.last  = (scanned == fill);

  always_comb begin
    if (cmd.start) begin
      rd_addr = head;
    end else if (cmd.step) begin
      rd_addr = wrap_inc(rd_ptr);
    end else begin
      rd_addr = rd_ptr;
    end
  end

  always_comb begin
    if (cmd.enq) begin
      fill_next = fill + CW'(1);
    end else if (cmd.hit) begin
      fill_next = fill - scanned;
    end else begin
      fill_next = fill;
    end
  end

  // queue storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      mem[tail] <= value;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_addr;
    if (cmd.start) begin
      key <= value;
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + AW'(1);
    end
    if (cmd.load) begin
      status <= cmd.res_status;
      count  <= 4'(fill_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (cmd.enq) begin
        tail <= wrap_inc(tail);
      end
      if (cmd.hit) begin
        head <= wrap_inc(rd_ptr);
      end
    end
  end

endmodule

FILE: test/qftm_checker.sv
module qftm_checker #(
  parameter int DEPTH = qftm_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [3:0]         count,
  output int                 fail_count,
  output int                 pending,
  output int                 n_ok,
  output int                 n_overflow,
  output int                 n_empty,
  output int                 n_notfound
);

  typedef struct packed {
    qftm_pkg::status_t st;
    logic [3:0]        cnt;
  } outcome_t;

  // shadow copy of the queue
  logic signed [31:0] held_vals [DEPTH];
  int                 held_cnt = 0;

  outcome_t outcome_q [$];
  int       errs = 0;
  int       tally [4] = '{0, 0, 0, 0};

  // updates the shadow queue for one transaction and returns its result
  function automatic outcome_t apply_item(input logic act, input logic signed [31:0] v);
    outcome_t o;
    int       hit;
    int       keep;
    hit  = -1;
    o.st = qftm_pkg::ST_OK;
    if (act == qftm_pkg::ACT_ENQUEUE) begin
      if (held_cnt < DEPTH) begin
        held_vals[held_cnt] = v;
        held_cnt++;
      end else begin
        o.st = qftm_pkg::ST_OVERFLOW;
      end
    end else if (held_cnt == 0) begin
      o.st = qftm_pkg::ST_EMPTY;
    end else begin
      for (int i = 0; i < held_cnt; i++) begin
        if (hit < 0 && held_vals[i] == v) hit = i;
      end
      if (hit < 0) begin
        o.st = qftm_pkg::ST_NOTFOUND;
      end else begin
        // drop head through the match, slide the rest forward in order
        keep = held_cnt - (hit + 1);
        for (int k = 0; k < keep; k++) held_vals[k] = held_vals[hit + 1 + k];
        held_cnt = keep;
      end
    end
    o.cnt = 4'(held_cnt);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      held_cnt = 0;
      outcome_q.delete();
    end else begin
      // results are registered, so one leaving now never comes from a transaction taken now
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got status %0d count %0d",
                   $time, status, count);
        end else begin
          want = outcome_q.pop_front();
          tally[want.st]++;
          if (status !== want.st) begin
            errs++;
            $display("%0t: status mismatch: expected %0d (%s), got %0d",
                     $time, want.st, want.st.name(), status);
          end
          if (count !== want.cnt) begin
            errs++;
            $display("%0t: count mismatch: expected %0d, got %0d",
                     $time, want.cnt, count);
          end
        end
      end
      if (in_valid && in_ready) outcome_q.push_back(apply_item(action, value));
    end
    fail_count <= errs;
    pending    <= outcome_q.size();
    n_ok       <= tally[qftm_pkg::ST_OK];
    n_overflow <= tally[qftm_pkg::ST_OVERFLOW];
    n_empty    <= tally[qftm_pkg::ST_EMPTY];
    n_notfound <= tally[qftm_pkg::ST_NOTFOUND];
  end

endmodule

FILE: test/queue_flush_through_match_top_tb.sv
module queue_flush_through_match_top_tb;

  localparam int RANDOM_ITEMS = 1680;
  localparam int QUIET_TAIL   = 150;   // last transactions run with no idling
  localparam int LONG_HOLD    = 120;   // receiver hold-off, long enough to back up the input
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake on either channel
  localparam int POOL_N       = 4;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = qftm_pkg::ACT_ENQUEUE;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [3:0]         count;

  int fail_count, pending, n_ok, n_overflow, n_empty, n_notfound;

  // shared between the sender and receiver processes
  bit quiet = 1'b0;          // no idling on either side
  bit long_hold_req = 1'b0;  // sender asks receiver for one long hold-off
  int sent = 0;
  int stall_cycles = 0;

  logic signed [31:0] pool [POOL_N];

  queue_flush_through_match_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count)
  );

  qftm_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .count      (count),
    .fail_count (fail_count),
    .pending    (pending),
    .n_ok       (n_ok),
    .n_overflow (n_overflow),
    .n_empty    (n_empty),
    .n_notfound (n_notfound)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: any stretch without a transaction on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending);
        $display("queue_flush_through_match_top_tb failed");
        $finish;
      end
    end
  end

  // Receiver: random ready bursts and stalls; one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, quiet ? 1 : 40)) @(posedge clk);
      end
    end
  end

  // Offer one transaction and hold it until accepted. Valid is left high on return,
  // so back-to-back calls never lower and raise it in the same step.
  task automatic offer(input logic act, input logic signed [31:0] v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);  // lets the checker count the last accepted transaction
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                 enq_pct;
    logic               act;
    logic signed [31:0] v;
    logic [31:0]        bitflip;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush, fill to full with extremes, overflow, misses, hits
    offer(qftm_pkg::ACT_FLUSH,   32'sd0);          // empty
    offer(qftm_pkg::ACT_ENQUEUE, VAL_MIN);
    offer(qftm_pkg::ACT_ENQUEUE, VAL_MAX);
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd0);
    offer(qftm_pkg::ACT_ENQUEUE, -32'sd1);
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd1);
    offer(qftm_pkg::ACT_ENQUEUE, 32'sh5555_5555);
    offer(qftm_pkg::ACT_ENQUEUE, 32'shaaaa_aaaa);
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd5);          // now full
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd9);          // overflow
    offer(qftm_pkg::ACT_FLUSH,   32'sh7fff_fffe);  // one bit off an entry: miss
    offer(qftm_pkg::ACT_FLUSH,   32'sh0000_0001 | VAL_MIN);  // top bit differs from 1: miss
    offer(qftm_pkg::ACT_FLUSH,   32'sd0);          // hit in the middle
    offer(qftm_pkg::ACT_FLUSH,   32'sd5);          // hit at the tail, empties queue
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd7);
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd7);
    offer(qftm_pkg::ACT_ENQUEUE, 32'sd7);
    offer(qftm_pkg::ACT_FLUSH,   -32'sd1);         // miss on partial queue
    offer(qftm_pkg::ACT_FLUSH,   32'sd7);          // duplicates: only the first goes
    offer(qftm_pkg::ACT_FLUSH,   32'sd7);
    offer(qftm_pkg::ACT_FLUSH,   32'sd7);
    offer(qftm_pkg::ACT_FLUSH,   32'sd7);          // empty again
    offer(qftm_pkg::ACT_ENQUEUE, VAL_MIN);
    offer(qftm_pkg::ACT_FLUSH,   VAL_MIN);         // hit at the head
    drain();

    // random: values mostly from a small pool so flushes find matches,
    // phases lean toward filling or toward flushing
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        for (int p = 0; p < POOL_N; p++) begin
          case ($urandom_range(0, 7))
            0:       pool[p] = VAL_MIN;
            1:       pool[p] = VAL_MAX;
            default: pool[p] = $urandom;
          endcase
        end
        case ($urandom_range(0, 2))
          0:       enq_pct = 75;
          1:       enq_pct = 35;
          default: enq_pct = 55;
        endcase
      end
      // sender pause until all results are back, kept out of the idle-free tail
      if (n > 0 && n % 400 == 0 && n < RANDOM_ITEMS - QUIET_TAIL) drain();
      if (n == 600) long_hold_req = 1'b1;
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;

      act = ($urandom_range(0, 99) < enq_pct) ? qftm_pkg::ACT_ENQUEUE : qftm_pkg::ACT_FLUSH;
      case ($urandom_range(0, 9))
        0: begin
          bitflip = 32'h1 << $urandom_range(0, 31);
          v = pool[$urandom_range(0, POOL_N - 1)] ^ bitflip;  // near miss
        end
        1: v = $urandom;
        2: begin
          case ($urandom_range(0, 3))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = 32'sd0;
            default: v = -32'sd1;
          endcase
        end
        default: v = pool[$urandom_range(0, POOL_N - 1)];
      endcase
      offer(act, v);
    end

    drain();
    repeat (30) @(posedge clk);  // catch any stray result after the last one

    $display("%0d transactions sent; results checked: %0d ok, %0d overflow, %0d empty,",
             sent, n_ok, n_overflow, n_empty);
    $display("%0d not found; covered directed extremes, long output back-pressure,",
             n_notfound);
    $display("drain pauses and an idle-free tail");
    if (fail_count == 0 && pending == 0) begin
      $display("queue_flush_through_match_top_tb passed");
    end else begin
      $display("queue_flush_through_match_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/qftm_pkg.sv
src/qftm_ctrl.sv
src/qftm_dpath.sv
src/queue_flush_through_match_top.sv
test/qftm_checker.sv
test/queue_flush_through_match_top_tb.sv
